// ----- rtl/jcs_pkg.sv -----
// Shared types, character codes and the per-byte judge function for the
// JSON comment stripper. No dependencies.
`timescale 1ns / 1ps

package jcs_pkg;

   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NUL       = 8'h00;

   // output queue depth and pointer width
   localparam int OUT_DEPTH = 4;
   localparam int PTR_W     = $clog2(OUT_DEPTH);
   localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_STRING = 2'd1,
      MODE_LINE   = 2'd2,
      MODE_BLOCK  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       text_done;
   } entry_type;

   // up to two result entries per accepted byte; v1 implies v0
   typedef struct packed {
      logic      v0;
      entry_type e0;
      logic      v1;
      entry_type e1;
   } push_type;

   typedef struct packed {
      mode_type mode;
      logic     keep;
      logic     consumed;
   } judge_type;

   // Judge byte c against lookahead nx in the given mode.
   function automatic judge_type judge(input mode_type mode, input logic [7:0] c,
                                       input logic [7:0] nx, input logic prev_bs);
      judge_type r;
      r.mode     = mode;
      r.keep     = 1'b0;
      r.consumed = 1'b0;
      case (mode)
         MODE_LINE: begin
            if (c == CH_NEWLINE) begin
               r.mode = MODE_NORMAL;
               r.keep = 1'b1;
            end
         end
         MODE_BLOCK: begin
            if (c == CH_STAR && nx == CH_SLASH) begin
               r.mode     = MODE_NORMAL;
               r.consumed = 1'b1;
            end
         end
         MODE_NORMAL, MODE_STRING: begin
            if (mode == MODE_NORMAL && c == CH_SLASH && nx == CH_SLASH) begin
               r.mode     = MODE_LINE;
               r.consumed = 1'b1;
            end else if (mode == MODE_NORMAL && c == CH_SLASH && nx == CH_STAR) begin
               r.mode     = MODE_BLOCK;
               r.consumed = 1'b1;
            end else begin
               r.keep = 1'b1;
               if (c == CH_QUOTE && !prev_bs) begin
                  r.mode = (mode == MODE_NORMAL) ? MODE_STRING : MODE_NORMAL;
               end
            end
         end
         default: begin
            r.mode = MODE_NORMAL;
         end
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/json_comment_stripper.sv -----
// Top level of the JSON comment stripper: scanner plus result queue.
// Depends on jcs_pkg, jcs_scan and jcs_out_fifo.
`timescale 1ns / 1ps

// Strips // and /* */ comments from a JSON byte stream, one byte per
// transaction, req_tlast marking the final byte of a text. One byte is held
// back as lookahead, so a kept byte appears one transaction later; the final
// transaction flushes it and yields up to two results, the last carrying
// rsp_tlast (a bare end marker with rsp_tuser low if nothing was kept).
// A byte is taken every cycle while the four-entry result queue has two free
// slots; the queue drains one result a cycle and a text never yields more
// results than it has bytes (its first byte yields none unless it is also its
// last), so with rsp_tready held high req_tready never drops. Each result is
// registered in the queue before rsp_tvalid offers it.

module json_comment_stripper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tlast,   // text_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // byte_present
   output logic       rsp_tlast    // text_done
);
   import jcs_pkg::*;

   push_type  push;
   entry_type out_entry;
   logic      room;
   logic      accept;

   assign req_tready = room;
   assign accept     = req_tvalid && room;

   jcs_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .push      (push)
   );

   jcs_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_entry (out_entry)
   );

   assign rsp_tdata = out_entry.out_byte;
   assign rsp_tuser = out_entry.byte_present;
   assign rsp_tlast = out_entry.text_done;

endmodule

// ----- rtl/jcs_scan.sv -----
// Scanner: mode and lookahead state, judges the held byte against each new
// byte and emits up to two result entries. Depends on jcs_pkg.
`timescale 1ns / 1ps

module jcs_scan (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_accept,
   input  logic [7:0]      in_byte,
   input  logic            in_last,
   output jcs_pkg::push_type push
);
   import jcs_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [7:0] held_ff, held_in;
   logic       held_valid_ff, held_valid_in;
   logic       prev_bs_ff, prev_bs_in;

   judge_type  j1, j2;
   logic       b_prev_bs;
   logic       keep1, keep2, consumed;
   mode_type   mode1;

   always_comb begin
      b_prev_bs = (held_ff == CH_BACKSLASH);
      j1 = judge(mode_ff, held_ff, in_byte, prev_bs_ff);
      keep1    = held_valid_ff && j1.keep;
      consumed = held_valid_ff && j1.consumed;
      mode1    = held_valid_ff ? j1.mode : mode_ff;
      // final byte is judged with a NUL lookahead
      j2 = judge(mode1, in_byte, CH_NUL, b_prev_bs);
      keep2 = in_last && !consumed && j2.keep;

      push.v0 = in_accept && (keep1 || in_last);
      if (keep1) begin
         push.e0 = '{out_byte: held_ff, byte_present: 1'b1, text_done: in_last && !keep2};
      end else if (keep2) begin
         push.e0 = '{out_byte: in_byte, byte_present: 1'b1, text_done: 1'b1};
      end else begin
         push.e0 = '{out_byte: CH_NUL, byte_present: 1'b0, text_done: 1'b1};
      end
      push.v1 = in_accept && keep1 && keep2;
      push.e1 = '{out_byte: in_byte, byte_present: 1'b1, text_done: 1'b1};

      mode_in       = mode_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      prev_bs_in    = prev_bs_ff;
      if (in_accept) begin
         if (in_last) begin
            mode_in       = MODE_NORMAL;
            held_in       = CH_NUL;
            held_valid_in = 1'b0;
            prev_bs_in    = 1'b0;
         end else begin
            mode_in       = mode1;
            held_in       = in_byte;
            held_valid_in = !consumed;
            prev_bs_in    = b_prev_bs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NORMAL;
         held_ff       <= CH_NUL;
         held_valid_ff <= 1'b0;
         prev_bs_ff    <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         prev_bs_ff    <= prev_bs_in;
      end
   end

endmodule

// ----- rtl/jcs_out_fifo.sv -----
// Result queue: takes up to two entries a cycle, hands out one a cycle.
// Depends on jcs_pkg.
`timescale 1ns / 1ps

module jcs_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  jcs_pkg::push_type push,
   output logic              room,
   output logic              out_valid,
   input  logic              out_ready,
   output jcs_pkg::entry_type out_entry
);
   import jcs_pkg::*;

   entry_type         mem_ff [OUT_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  wr_ptr_next;
   logic              pop;
   logic [CNT_W-1:0]  n_push;

   always_comb begin
      out_valid   = (count_ff != '0);
      out_entry   = mem_ff[rd_ptr_ff];
      // two free slots so a final byte can always push both results
      room        = (count_ff <= CNT_W'(OUT_DEPTH - 2));
      pop         = out_valid && out_ready;
      wr_ptr_next = wr_ptr_ff + PTR_W'(1);
      n_push      = CNT_W'(push.v0) + CNT_W'(push.v1);
      wr_ptr_in   = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in   = rd_ptr_ff + PTR_W'(pop);
      count_in    = count_ff + n_push - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         mem_ff[wr_ptr_ff] <= push.e0;
      end
      if (push.v1) begin
         mem_ff[wr_ptr_next] <= push.e1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/jcs_checker.sv -----
// Port-level checks for the JSON comment stripper, bound to the top level.
// Depends on json_comment_stripper.
`timescale 1ns / 1ps

module jcs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // queue is empty and open right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("results pending or input closed after reset");

   // a bare marker only closes a text
   a_bare_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("bare marker without end of text");

   a_bare_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 8'h00))
      else $error("bare marker carries data");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped while stalled");

endmodule

bind json_comment_stripper jcs_checker u_jcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- dv/tb.sv -----
// Testbench for json_comment_stripper: streams byte texts in, predicts the
// stripped output per accepted byte and checks every result transaction.
// Depends on jcs_pkg and the json_comment_stripper RTL.
`timescale 1ns / 1ps

module tb;
   import jcs_pkg::*;

// Tracks the scanner state and queues the results each accepted byte should produce.
class strip_scoreboard;
   mode_type   scan_mode;
   logic [7:0] held_byte;
   bit         held_valid;
   bit         held_after_bs;
   entry_type  results_due[$];
   int         mismatches;
   int         results_seen;
   int         texts_seen;
   int         bare_markers;

   function new();
      clear_state();
      mismatches   = 0;
      results_seen = 0;
      texts_seen   = 0;
      bare_markers = 0;
   endfunction

   function void clear_state();
      scan_mode     = MODE_NORMAL;
      held_byte     = CH_NUL;
      held_valid    = 1'b0;
      held_after_bs = 1'b0;
   endfunction

   // decide byte c given lookahead nx; updates scan_mode
   function void classify(input logic [7:0] c, input logic [7:0] nx, input bit prev_bs,
                          output bit keep, output bit consumed);
      keep     = 1'b0;
      consumed = 1'b0;
      case (scan_mode)
         MODE_LINE: begin
            if (c == CH_NEWLINE) begin
               scan_mode = MODE_NORMAL;
               keep      = 1'b1;
            end
         end
         MODE_BLOCK: begin
            if (c == CH_STAR && nx == CH_SLASH) begin
               scan_mode = MODE_NORMAL;
               consumed  = 1'b1;
            end
         end
         default: begin
            if (scan_mode == MODE_NORMAL && c == CH_SLASH &&
                (nx == CH_SLASH || nx == CH_STAR)) begin
               scan_mode = (nx == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
               consumed  = 1'b1;
            end else begin
               keep = 1'b1;
               if (c == CH_QUOTE && !prev_bs)
                  scan_mode = (scan_mode == MODE_NORMAL) ? MODE_STRING : MODE_NORMAL;
            end
         end
      endcase
   endfunction

   function void take_byte(input logic [7:0] b, input bit last);
      bit        prev_is_bs;
      bit        keep;
      bit        consumed;
      bit        unused;
      entry_type item;
      entry_type produced[$];
      prev_is_bs = (held_byte == CH_BACKSLASH);
      consumed   = 1'b0;
      if (held_valid) begin
         classify(held_byte, b, held_after_bs, keep, consumed);
         if (keep) begin
            item     = '{out_byte: held_byte, byte_present: 1'b1, text_done: 1'b0};
            produced = {produced, item};
         end
      end
      held_byte     = b;
      held_valid    = !consumed;
      held_after_bs = prev_is_bs;
      if (last) begin
         // final byte is judged against a NUL lookahead
         if (held_valid) begin
            classify(b, CH_NUL, prev_is_bs, keep, unused);
            if (keep) begin
               item     = '{out_byte: b, byte_present: 1'b1, text_done: 1'b0};
               produced = {produced, item};
            end
         end
         if (produced.size() == 0) begin
            item     = '{out_byte: CH_NUL, byte_present: 1'b0, text_done: 1'b1};
            produced = {produced, item};
            bare_markers++;
         end else begin
            produced[produced.size() - 1].text_done = 1'b1;
         end
         texts_seen++;
         clear_state();
      end
      results_due = {results_due, produced};
   endfunction

   function void match_result(input logic [7:0] data, input logic present, input logic done);
      entry_type want;
      results_seen++;
      if (results_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result transaction: data=%02h present=%0b done=%0b",
                     data, present, done);
         return;
      end
      want = results_due.pop_front();
      if (data !== want.out_byte || present !== want.byte_present ||
          done !== want.text_done) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch at result %0d: expected data=%02h present=%0b done=%0b,",
                      " got data=%02h present=%0b done=%0b"},
                     results_seen, want.out_byte, want.byte_present, want.text_done,
                     data, present, done);
      end
   endfunction
endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;

   strip_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_request;
   int bytes_sent;

   json_comment_stripper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side: random back-pressure plus an occasional long hold-off
   initial begin : rsp_side
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.match_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // called at a rising edge; returns at the edge where the byte was taken
   task automatic send_byte(input logic [7:0] b, input bit last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.take_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] pick_text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 14) return CH_SLASH;
      if (r < 26) return CH_STAR;
      if (r < 33) return CH_NEWLINE;
      if (r < 43) return CH_QUOTE;
      if (r < 49) return CH_BACKSLASH;
      if (r < 59) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(32, 126));
   endfunction

   task automatic send_random_text();
      int len;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 16);
      for (int i = 0; i < len; i++)
         send_byte(pick_text_byte(), i == len - 1);
   endtask

   // stop offering bytes until every predicted result has been seen
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.results_due.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int target;
      sb            = new();
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      hold_request  = 0;
      bytes_sent    = 0;
      send_idle_pct = 21;
      recv_idle_pct = 49;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: line comment, block opener/closer overlap, escaped quote in
      // a string, lone quote at start, text that leaves only an end marker,
      // extreme byte values
      send_text("a//x\n");
      send_text("/*/*/");
      send_text("\"\\\"//\"");
      send_text("\"");
      send_text("//");
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b1);
      drain();

      // long hold on the result side while bytes keep coming
      hold_request = 60;
      for (int i = 0; i < 40; i++)
         send_byte(8'($urandom_range(32, 126)), i == 39);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 21; recv_idle_pct = 49; end
            1: begin send_idle_pct = 49; recv_idle_pct = 21; end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_request  = 80;
            end
         endcase
         target = bytes_sent + 660;
         while (bytes_sent < target) send_random_text();
         drain();
      end

      repeat (16) @(posedge clock);
      $display("covered %0d texts and %0d bytes under varied back-pressure",
               sb.texts_seen, bytes_sent);
      $display("checked %0d result transactions, %0d of them bare end markers",
               sb.results_seen, sb.bare_markers);
      if (sb.mismatches == 0 && sb.results_due.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("timeout with %0d results outstanding", sb.results_due.size());
      $display("status: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/jcs_pkg.sv
rtl/jcs_scan.sv
rtl/jcs_out_fifo.sv
rtl/json_comment_stripper.sv
rtl/jcs_checker.sv
dv/tb.sv
